[design/plm_pkg.sv]
// Package for the peer liveness monitor: sizes, event and action codes,
// register indexes, sequencer states and the structs passed between modules.
// No dependencies.
package plm_pkg;

  localparam int SLOTS       = 16;
  localparam int IDX_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W       = $clog2(SLOTS + 1);
  localparam int NODE_W      = 8;
  localparam int TIME_W      = 32;
  localparam int ACT_W       = 2;
  localparam int KIND_W      = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int ACTIVE_W    = 5;

  localparam logic [NODE_W-1:0]   BCAST_NODE        = 8'hFF;
  localparam logic [TIME_W-1:0]   SEND_INTERVAL_RST = 32'd1000;
  localparam logic [TIME_W-1:0]   LOSS_TIMEOUT_RST  = 32'd3000;
  localparam logic [ACTIVE_W-1:0] ACTIVE_SLOTS_RST  = 5'd16;

  typedef enum logic [ACT_W-1:0] {
    ACT_TICK      = 2'd0,
    ACT_HEARTBEAT = 2'd1,
    ACT_ADD       = 2'd2,
    ACT_QUERY     = 2'd3
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE  = 3'd0,
    EV_SEND  = 3'd1,
    EV_LOST  = 3'd2,
    EV_FOUND = 3'd3,
    EV_ADD   = 3'd4,
    EV_QUERY = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SEND_INTERVAL = 2'd0,
    REG_LOSS_TIMEOUT  = 2'd1,
    REG_ACTIVE_SLOTS  = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEND,
    S_READ,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    event_t              kind;
    logic [NODE_W-1:0]   node;
    logic                flag;
  } result_t;

  typedef struct packed {
    logic                we;
    logic [IDX_W-1:0]    idx;
    logic [NODE_W-1:0]   node;
    logic [TIME_W-1:0]   seen;
  } slot_wr_t;

  typedef struct packed {
    logic                set_used;
    logic                set_alive;
    logic                clr_alive;
    logic [IDX_W-1:0]    idx;
  } flag_op_t;

endpackage

[design/plm_ifaces.sv]
// Handshake channels of the peer liveness monitor: input item, result item
// and configuration write. Depends on plm_pkg.
interface plm_item_if;
  logic                         valid;
  logic                         ready;
  logic [plm_pkg::ACT_W-1:0]    action;
  logic [plm_pkg::NODE_W-1:0]   node_id;
  modport source (output valid, action, node_id, input ready);
  modport sink (input valid, action, node_id, output ready);
endinterface

interface plm_result_if;
  logic                         valid;
  logic                         ready;
  logic [plm_pkg::KIND_W-1:0]   event_kind;
  logic [plm_pkg::NODE_W-1:0]   peer_node;
  logic                         flag;
  logic                         last;
  modport source (output valid, event_kind, peer_node, flag, last, input ready);
  modport sink (input valid, event_kind, peer_node, flag, last, output ready);
endinterface

interface plm_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [plm_pkg::CFG_IDX_W-1:0]  index;
  logic [plm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/plm_slot_table.sv]
// Peer slot table: a synchronous memory of node id and last-seen time per slot
// (registered read data) plus the used and alive flags in flip-flops.
// Depends on plm_pkg.
module plm_slot_table (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [plm_pkg::IDX_W-1:0]     rd_idx,
  input  plm_pkg::slot_wr_t             wr,
  input  plm_pkg::flag_op_t             fop,
  output logic [plm_pkg::NODE_W-1:0]    rd_node,
  output logic [plm_pkg::TIME_W-1:0]    rd_seen,
  output logic [plm_pkg::SLOTS-1:0]     used,
  output logic [plm_pkg::SLOTS-1:0]     alive
);
  import plm_pkg::*;

  logic [NODE_W+TIME_W-1:0] mem [SLOTS];
  logic [NODE_W+TIME_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= {wr.node, wr.seen};
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

  assign rd_node = rd_data[NODE_W+TIME_W-1:TIME_W];
  assign rd_seen = rd_data[TIME_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      alive <= '0;
    end else begin
      if (fop.set_used) begin
        used[fop.idx] <= 1'b1;
      end
      if (fop.set_alive) begin
        alive[fop.idx] <= 1'b1;
      end else if (fop.clr_alive) begin
        alive[fop.idx] <= 1'b0;
      end
    end
  end

endmodule

[design/peer_liveness_monitor_core.sv]
// Top level of the peer liveness monitor: sequencer, configuration registers,
// millisecond clock and result register. Depends on plm_pkg, plm_ifaces and
// plm_slot_table.
//
//   Channel     Dir  Payload                               Accepted when
//   item_in     in   action, node_id                       valid & ready
//   result_out  out  event_kind, peer_node, flag, last     valid & ready
//   cfg         in   index, data                           valid & ready
//
// Each slot visited takes a memory read, then an evaluation, so a tick
// walks all N active slots one after another; a heartbeat, add or query
// stops at the matching slot. The single memory read port sets this pace.
// Reset clears the clock and the flags and restores the configuration defaults at once; no sweep.
// A stalled result output holds the scan only when a second result is due.
module peer_liveness_monitor_core (
  input  logic       clk,
  input  logic       rst,
  plm_cfg_if.sink    cfg,
  plm_item_if.sink   item_in,
  plm_result_if.source result_out
);
  import plm_pkg::*;

  logic [TIME_W-1:0]   send_interval;
  logic [TIME_W-1:0]   loss_timeout;
  logic [ACTIVE_W-1:0] active_slots;
  logic [TIME_W-1:0]   clock_ms;
  logic [TIME_W-1:0]   last_send_time;

  state_t              state, state_next;
  action_t             act;
  logic [NODE_W-1:0]   node;
  logic [CNT_W-1:0]    idx;
  logic [CNT_W-1:0]    limit;
  logic [IDX_W-1:0]    idx_lo;
  logic                free_found;
  logic [IDX_W-1:0]    free_idx;
  logic                pend_valid;
  result_t             pend;
  logic                out_valid;
  result_t             out_res;
  logic                out_last;

  logic                accept;
  logic                can_load;
  logic                load;
  result_t             load_res;
  logic                load_last;
  logic                pend_set;
  result_t             pend_res;
  logic                idx_inc;
  logic                free_set;
  logic                send_fire;
  logic                rd_en;
  slot_wr_t            wr;
  flag_op_t            fop;
  logic [NODE_W-1:0]   rd_node;
  logic [TIME_W-1:0]   rd_seen;
  logic [SLOTS-1:0]    used;
  logic [SLOTS-1:0]    alive;
  logic [TIME_W-1:0]   send_age;
  logic [TIME_W-1:0]   seen_age;
  logic                hit;
  logic                lost;

  plm_slot_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_idx  (idx_lo),
    .wr      (wr),
    .fop     (fop),
    .rd_node (rd_node),
    .rd_seen (rd_seen),
    .used    (used),
    .alive   (alive)
  );

  assign accept       = item_in.valid && item_in.ready;
  assign item_in.ready = (state == S_IDLE);
  assign cfg.ready    = (state == S_IDLE);
  assign can_load     = !out_valid || result_out.ready;

  assign limit  = (int'(active_slots) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(active_slots);
  assign idx_lo = idx[IDX_W-1:0];

  assign send_age = clock_ms - last_send_time;
  assign seen_age = clock_ms - rd_seen;
  assign hit      = used[idx_lo] && (rd_node == node);
  assign lost     = used[idx_lo] && alive[idx_lo] && (seen_age >= loss_timeout);

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    wr         = '0;
    fop        = '0;
    load       = 1'b0;
    load_res   = '0;
    load_last  = 1'b0;
    pend_set   = 1'b0;
    pend_res   = '0;
    idx_inc    = 1'b0;
    free_set   = 1'b0;
    send_fire  = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (action_t'(item_in.action) == ACT_TICK) ? S_SEND : S_READ;
        end
      end
      S_SEND: begin
        if (send_age >= send_interval) begin
          pend_set  = 1'b1;
          pend_res  = '{kind: EV_SEND, node: BCAST_NODE, flag: 1'b0};
          send_fire = 1'b1;
        end
        state_next = S_READ;
      end
      S_READ: begin
        if (idx >= limit) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        case (act)
          ACT_TICK: begin
            if (lost) begin
              // A new loss proves the held result is not the final one.
              if (!pend_valid || can_load) begin
                if (pend_valid) begin
                  load     = 1'b1;
                  load_res = pend;
                end
                pend_set      = 1'b1;
                pend_res      = '{kind: EV_LOST, node: rd_node, flag: 1'b0};
                fop.clr_alive = 1'b1;
                fop.idx       = idx_lo;
                idx_inc       = 1'b1;
                state_next    = S_READ;
              end
            end else begin
              idx_inc    = 1'b1;
              state_next = S_READ;
            end
          end
          ACT_HEARTBEAT: begin
            if (hit) begin
              wr            = '{we: 1'b1, idx: idx_lo, node: node, seen: clock_ms};
              fop.set_alive = 1'b1;
              fop.idx       = idx_lo;
              if (!alive[idx_lo]) begin
                pend_set = 1'b1;
                pend_res = '{kind: EV_FOUND, node: node, flag: 1'b0};
              end
              state_next = S_DONE;
            end else begin
              idx_inc    = 1'b1;
              state_next = S_READ;
            end
          end
          ACT_ADD: begin
            if (hit) begin
              pend_set   = 1'b1;
              pend_res   = '{kind: EV_ADD, node: node, flag: 1'b1};
              state_next = S_DONE;
            end else begin
              if (!used[idx_lo] && !free_found) begin
                free_set = 1'b1;
              end
              idx_inc    = 1'b1;
              state_next = S_READ;
            end
          end
          ACT_QUERY: begin
            if (hit) begin
              pend_set   = 1'b1;
              pend_res   = '{kind: EV_QUERY, node: node, flag: alive[idx_lo]};
              state_next = S_DONE;
            end else begin
              idx_inc    = 1'b1;
              state_next = S_READ;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (can_load) begin
          load       = 1'b1;
          load_last  = 1'b1;
          state_next = S_IDLE;
          if (pend_valid) begin
            load_res = pend;
          end else begin
            case (act)
              ACT_ADD: begin
                load_res = '{kind: EV_ADD, node: node, flag: free_found};
                if (free_found) begin
                  wr            = '{we: 1'b1, idx: free_idx, node: node, seen: clock_ms};
                  fop.set_used  = 1'b1;
                  fop.set_alive = 1'b1;
                  fop.idx       = free_idx;
                end
              end
              ACT_QUERY: begin
                load_res = '{kind: EV_QUERY, node: node, flag: 1'b0};
              end
              default: begin
                load_res = '{kind: EV_NONE, node: '0, flag: 1'b0};
              end
            endcase
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_interval  <= SEND_INTERVAL_RST;
      loss_timeout   <= LOSS_TIMEOUT_RST;
      active_slots   <= ACTIVE_SLOTS_RST;
      clock_ms       <= '0;
      last_send_time <= '0;
      idx            <= '0;
      free_found     <= 1'b0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_SEND_INTERVAL: send_interval <= cfg.data;
          REG_LOSS_TIMEOUT:  loss_timeout  <= cfg.data;
          REG_ACTIVE_SLOTS:  active_slots  <= cfg.data[ACTIVE_W-1:0];
          default: begin
          end
        endcase
      end

      if (accept) begin
        act        <= action_t'(item_in.action);
        node       <= item_in.node_id;
        idx        <= '0;
        free_found <= 1'b0;
        if (action_t'(item_in.action) == ACT_TICK) begin
          clock_ms <= clock_ms + TIME_W'(1);
        end
      end else if (idx_inc) begin
        idx <= idx + CNT_W'(1);
      end

      if (send_fire) begin
        last_send_time <= clock_ms;
      end

      if (free_set) begin
        free_found <= 1'b1;
        free_idx   <= idx_lo;
      end

      if (pend_set) begin
        pend_valid <= 1'b1;
        pend       <= pend_res;
      end else if (state == S_DONE && can_load) begin
        pend_valid <= 1'b0;
      end

      if (load) begin
        out_valid <= 1'b1;
        out_res   <= load_res;
        out_last  <= load_last;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result_out.valid      = out_valid;
  assign result_out.event_kind = out_res.kind;
  assign result_out.peer_node  = out_res.node;
  assign result_out.flag       = out_res.flag;
  assign result_out.last       = out_last;

  // A held result is always sent, as the final one, before the block idles.
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !pend_valid)
    else $error("held result left over in idle");

  // Evaluation only ever follows a memory read or a stalled evaluation.
  a_eval_after_read: assert property (@(posedge clk) disable iff (rst)
    (state == S_EVAL) |-> ($past(state) == S_READ || $past(state) == S_EVAL))
    else $error("slot evaluated without a read in flight");

  // A tick advances the millisecond clock by exactly one.
  a_tick_clock: assert property (@(posedge clk) disable iff (rst)
    (accept && action_t'(item_in.action) == ACT_TICK)
      |=> (clock_ms == $past(clock_ms) + TIME_W'(1)))
    else $error("tick did not advance the clock");

endmodule

[test/tb_top.sv]
// Self-checking testbench for peer_liveness_monitor_core: directed and random items
// are scored against an in-bench model of the slot table and the millisecond clock.
// Depends on plm_pkg, the plm channel interfaces and the design sources.
module tb_top;
  import plm_pkg::*;

  typedef struct packed {
    event_t              kind;
    logic [NODE_W-1:0]   node;
    logic                flag;
    logic                last;
  } liveness_event_t;

  logic clk;
  logic rst;

  plm_cfg_if    cfg_bus ();
  plm_item_if   item_bus ();
  plm_result_if result_bus ();

  peer_liveness_monitor_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg_bus),
    .item_in    (item_bus),
    .result_out (result_bus)
  );

  // Shadow copy of the block's registers and table.
  logic [TIME_W-1:0]   cur_interval;
  logic [TIME_W-1:0]   cur_timeout;
  logic [ACTIVE_W-1:0] cur_active;
  logic [TIME_W-1:0]   ms_now;
  logic [TIME_W-1:0]   ms_last_bcast;
  logic                tbl_used  [SLOTS];
  logic                tbl_alive [SLOTS];
  logic [NODE_W-1:0]   tbl_node  [SLOTS];
  logic [TIME_W-1:0]   tbl_seen  [SLOTS];

  liveness_event_t events_due [$];
  liveness_event_t due_event;
  int              mismatch_count;
  int              burst_left;
  bit              sender_gaps;
  logic [NODE_W-1:0] node_pool [20];

  int rx_cycle;
  int rx_mode;
  int rx_hold;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #15000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic liveness_event_t mk_event(event_t kind, logic [NODE_W-1:0] node,
                                               logic flag);
    liveness_event_t ev;
    ev.kind = kind;
    ev.node = node;
    ev.flag = flag;
    ev.last = 1'b0;
    return ev;
  endfunction

  // Applies one accepted item to the shadow state and queues the events it causes.
  function automatic void advance_liveness(action_t act, logic [NODE_W-1:0] nid);
    liveness_event_t evs [$];
    liveness_event_t ev;
    int              span;
    int              hit;
    bit              placed;
    span = (cur_active > SLOTS) ? SLOTS : int'(cur_active);
    hit = -1;
    placed = 1'b0;
    for (int i = 0; i < span; i++)
      if (hit < 0 && tbl_used[i] && tbl_node[i] == nid) hit = i;
    case (act)
      ACT_TICK: begin
        ms_now = ms_now + 1;
        if (TIME_W'(ms_now - ms_last_bcast) >= cur_interval) begin
          evs.push_back(mk_event(EV_SEND, BCAST_NODE, 1'b0));
          ms_last_bcast = ms_now;
        end
        for (int i = 0; i < span; i++) begin
          if (tbl_used[i] && tbl_alive[i] && TIME_W'(ms_now - tbl_seen[i]) >= cur_timeout) begin
            tbl_alive[i] = 1'b0;
            evs.push_back(mk_event(EV_LOST, tbl_node[i], 1'b0));
          end
        end
      end
      ACT_HEARTBEAT: begin
        if (hit >= 0) begin
          if (!tbl_alive[hit]) evs.push_back(mk_event(EV_FOUND, nid, 1'b0));
          tbl_seen[hit] = ms_now;
          tbl_alive[hit] = 1'b1;
        end
      end
      ACT_ADD: begin
        if (hit >= 0) begin
          evs.push_back(mk_event(EV_ADD, nid, 1'b1));
        end else begin
          for (int i = 0; i < span; i++) begin
            if (!placed && !tbl_used[i]) begin
              tbl_used[i] = 1'b1;
              tbl_alive[i] = 1'b1;
              tbl_node[i] = nid;
              tbl_seen[i] = ms_now;
              placed = 1'b1;
            end
          end
          evs.push_back(mk_event(EV_ADD, nid, placed));
        end
      end
      default: begin
        evs.push_back(mk_event(EV_QUERY, nid, (hit >= 0) ? tbl_alive[hit] : 1'b0));
      end
    endcase
    if (evs.size() == 0) evs.push_back(mk_event(EV_NONE, '0, 1'b0));
    for (int k = 0; k < evs.size(); k++) begin
      ev = evs[k];
      ev.last = (k == evs.size() - 1);
      events_due.push_back(ev);
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= 40)
      $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  // Result scoreboard.
  always @(posedge clk) begin
    if (!rst && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
      if (events_due.size() == 0) begin
        report_mismatch("result with nothing due", 32'(result_bus.event_kind), 0);
      end else begin
        due_event = events_due.pop_front();
        if (result_bus.event_kind !== due_event.kind)
          report_mismatch("event_kind", 32'(result_bus.event_kind), 32'(due_event.kind));
        if (result_bus.peer_node !== due_event.node)
          report_mismatch("peer_node", 32'(result_bus.peer_node), 32'(due_event.node));
        if (result_bus.flag !== due_event.flag)
          report_mismatch("flag", 32'(result_bus.flag), 32'(due_event.flag));
        if (result_bus.last !== due_event.last)
          report_mismatch("last", 32'(result_bus.last), 32'(due_event.last));
      end
    end
  end

  // Result stalls: the style of back-pressure is redrawn at random whenever the low byte of rx_cycle is zero.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[7:0] == 8'd0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: result_bus.ready <= 1'b1;
      1: result_bus.ready <= ($urandom_range(0, 3) != 0);
      2: result_bus.ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
          result_bus.ready <= 1'b0;
        end else begin
          result_bus.ready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 12);
        end
      end
    endcase
  end

  task automatic send_item(action_t act, logic [NODE_W-1:0] nid);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = sender_gaps ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        item_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_bus.valid   <= 1'b1;
    item_bus.action  <= act;
    item_bus.node_id <= nid;
    do @(posedge clk); while (item_bus.ready !== 1'b1);
    advance_liveness(act, nid);
  endtask

  // Stops the sender and waits until every queued event has come back.
  task automatic drain_results();
    item_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    do @(posedge clk); while (cfg_bus.ready !== 1'b1);
    case (idx)
      REG_SEND_INTERVAL: cur_interval = value;
      REG_LOSS_TIMEOUT:  cur_timeout = value;
      default:           cur_active = value[ACTIVE_W-1:0];
    endcase
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [NODE_W-1:0] pick_node();
    if ($urandom_range(0, 6) == 0) return NODE_W'($urandom_range(0, 255));
    return node_pool[$urandom_range(0, 19)];
  endfunction

  // Default registers: add, duplicate add, queries and heartbeats on known and unknown peers, and a tick.
  task automatic test_basic_ops();
    send_item(ACT_QUERY, 8'h00);
    send_item(ACT_ADD, 8'h00);
    send_item(ACT_ADD, 8'hFF);
    send_item(ACT_ADD, 8'h00);
    send_item(ACT_QUERY, 8'h00);
    send_item(ACT_HEARTBEAT, 8'hFF);
    send_item(ACT_HEARTBEAT, 8'h5A);
    send_item(ACT_TICK, 8'hC3);
    drain_results();
  endtask

  // A zero interval sends on every tick and a zero timeout drops every live peer.
  task automatic test_zero_limits();
    write_reg(REG_SEND_INTERVAL, 32'd0);
    write_reg(REG_LOSS_TIMEOUT, 32'd0);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_HEARTBEAT, 8'h00);
    send_item(ACT_QUERY, 8'h00);
    send_item(ACT_QUERY, 8'hFF);
    send_item(ACT_TICK, 8'hFF);
    drain_results();
  endtask

  // Full table, slots hidden by a smaller count, and a count above the built size.
  task automatic test_slot_count();
    write_reg(REG_ACTIVE_SLOTS, 32'd2);
    send_item(ACT_ADD, 8'hA5);
    drain_results();
    write_reg(REG_ACTIVE_SLOTS, 32'd1);
    send_item(ACT_QUERY, 8'hFF);
    send_item(ACT_HEARTBEAT, 8'hFF);
    send_item(ACT_TICK, 8'h00);
    drain_results();
    write_reg(REG_ACTIVE_SLOTS, 32'd0);
    send_item(ACT_ADD, 8'h33);
    send_item(ACT_TICK, 8'h00);
    drain_results();
    write_reg(REG_ACTIVE_SLOTS, 32'd31);
    send_item(ACT_HEARTBEAT, 8'hFF);
    send_item(ACT_ADD, 8'h33);
    drain_results();
  endtask

  task automatic test_max_limits();
    write_reg(REG_SEND_INTERVAL, 32'hFFFF_FFFF);
    write_reg(REG_LOSS_TIMEOUT, 32'hFFFF_FFFF);
    send_item(ACT_TICK, 8'h00);
    send_item(ACT_TICK, 8'hFF);
    send_item(ACT_QUERY, 8'h33);
    drain_results();
  endtask

  // Random traffic over a schedule of register settings; peers come from a small pool
  // so that heartbeats, losses and refinds keep hitting tracked slots.
  task automatic test_random_phases();
    logic [31:0]   ivl  [12];
    logic [31:0]   tmo  [12];
    logic [31:0]   cnt  [12];
    int            r;
    action_t       act;
    ivl = '{32'd7, 32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd12, 32'd5, 32'd2, 32'd0,
            32'd9, 32'd4, 32'd6};
    tmo = '{32'd10, 32'd4, 32'd0, 32'd12, 32'hFFFF_FFFF, 32'd6, 32'd1, 32'd9, 32'd8,
            32'd3, 32'd14, 32'd5};
    cnt = '{32'd16, 32'd4, 32'd31, 32'd1, 32'd0, 32'd8, 32'd17, 32'd16, 32'd2,
            32'd12, 32'd16, 32'd16};
    node_pool[0] = 8'h00;
    node_pool[1] = 8'hFF;
    for (int i = 2; i < 20; i++) node_pool[i] = NODE_W'($urandom_range(0, 255));
    for (int p = 0; p < 12; p++) begin
      write_reg(REG_SEND_INTERVAL, ivl[p]);
      write_reg(REG_LOSS_TIMEOUT, tmo[p]);
      write_reg(REG_ACTIVE_SLOTS, cnt[p]);
      sender_gaps = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 37; n++) begin
        r = $urandom_range(0, 99);
        act = (r < 50) ? ACT_TICK : (r < 72) ? ACT_HEARTBEAT : (r < 86) ? ACT_ADD : ACT_QUERY;
        send_item(act, (act == ACT_TICK) ? NODE_W'($urandom_range(0, 255)) : pick_node());
      end
      drain_results();
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = REG_SEND_INTERVAL;
    cfg_bus.data = '0;
    item_bus.valid = 1'b0;
    item_bus.action = ACT_TICK;
    item_bus.node_id = '0;
    result_bus.ready = 1'b0;
    rx_cycle = 0;
    rx_mode = 0;
    rx_hold = 0;
    mismatch_count = 0;
    burst_left = 0;
    sender_gaps = 1'b1;
    cur_interval = SEND_INTERVAL_RST;
    cur_timeout = LOSS_TIMEOUT_RST;
    cur_active = ACTIVE_SLOTS_RST;
    ms_now = '0;
    ms_last_bcast = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_alive[i] = 1'b0;
      tbl_node[i] = '0;
      tbl_seen[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_zero_limits();
    test_slot_count();
    test_max_limits();
    test_random_phases();

    drain_results();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && events_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
